// File: rtl/jpp_pkg.sv
// Package for the JSON pretty printer: payload structs, character codes,
// controller states and the command and status structs between the blocks.
// Depends on nothing.
`timescale 1ns / 1ps

package jpp_pkg;

  localparam int unsigned DepthW       = 5;
  localparam int unsigned SpaceW       = DepthW + 1;
  localparam int unsigned MaxDepthDflt = 31;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLbrace    = 8'h7B;
  localparam logic [7:0] ChRbrace    = 8'h7D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       doc_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       doc_end;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StHead,
    StNewline,
    StSpace,
    StTail
  } state_e;

  typedef enum logic [1:0] {
    SelHead,
    SelNewline,
    SelSpace,
    SelTail
  } sel_e;

  // Which parts of an output run a request produces.
  typedef struct packed {
    logic has_head;
    logic has_indent;
    logic has_tail;
  } plan_t;

  typedef struct packed {
    logic load;
    logic emit;
    sel_e sel;
    logic dec_space;
    logic run_last;
  } ctrl_cmd_t;

  typedef struct packed {
    plan_t in_plan;
    plan_t plan;
    logic  space_zero;
    logic  space_one;
    logic  out_free;
  } dp_status_t;

endpackage

// File: rtl/jpp_ctrl.sv
// Controller state machine of the JSON pretty printer: sequences the head
// byte, newline, indent spaces and tail byte of each run.
// Depends on jpp_pkg.
`timescale 1ns / 1ps

module jpp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jpp_pkg::dp_status_t status_i,
  output jpp_pkg::ctrl_cmd_t  cmd_o
);

  jpp_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_ready_o = (state_q == jpp_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jpp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      jpp_pkg::StIdle: begin
        if (accept) begin
          if (status_i.in_plan.has_head) begin
            state_d = jpp_pkg::StHead;
          end else if (status_i.in_plan.has_indent) begin
            state_d = jpp_pkg::StNewline;
          end else if (status_i.in_plan.has_tail) begin
            state_d = jpp_pkg::StTail;
          end
        end
      end
      jpp_pkg::StHead: begin
        if (status_i.out_free) begin
          if (status_i.plan.has_indent) begin
            state_d = jpp_pkg::StNewline;
          end else if (status_i.plan.has_tail) begin
            state_d = jpp_pkg::StTail;
          end else begin
            state_d = jpp_pkg::StIdle;
          end
        end
      end
      jpp_pkg::StNewline: begin
        if (status_i.out_free) begin
          if (!status_i.space_zero) begin
            state_d = jpp_pkg::StSpace;
          end else if (status_i.plan.has_tail) begin
            state_d = jpp_pkg::StTail;
          end else begin
            state_d = jpp_pkg::StIdle;
          end
        end
      end
      jpp_pkg::StSpace: begin
        if (status_i.out_free && status_i.space_one) begin
          state_d = status_i.plan.has_tail ? jpp_pkg::StTail : jpp_pkg::StIdle;
        end
      end
      jpp_pkg::StTail: begin
        if (status_i.out_free) begin
          state_d = jpp_pkg::StIdle;
        end
      end
      default: state_d = jpp_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.sel       = jpp_pkg::SelHead;
    cmd_o.load      = accept;
    case (state_q)
      jpp_pkg::StHead: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.sel      = jpp_pkg::SelHead;
        cmd_o.run_last = !status_i.plan.has_indent && !status_i.plan.has_tail;
      end
      jpp_pkg::StNewline: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.sel      = jpp_pkg::SelNewline;
        cmd_o.run_last = status_i.space_zero && !status_i.plan.has_tail;
      end
      jpp_pkg::StSpace: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.sel       = jpp_pkg::SelSpace;
        cmd_o.dec_space = status_i.out_free;
        cmd_o.run_last  = status_i.space_one && !status_i.plan.has_tail;
      end
      jpp_pkg::StTail: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.sel      = jpp_pkg::SelTail;
        cmd_o.run_last = 1'b1;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/jpp_datapath.sv
// Datapath of the JSON pretty printer: parser state, byte decode, the run
// plan and indent counter, and the output register.
// Depends on jpp_pkg.
`timescale 1ns / 1ps

module jpp_datapath #(
  parameter int unsigned MAX_DEPTH = jpp_pkg::MaxDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jpp_pkg::in_t       in_data_i,
  input  jpp_pkg::ctrl_cmd_t cmd_i,
  output jpp_pkg::dp_status_t status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jpp_pkg::out_t      out_data_o
);

  localparam logic [jpp_pkg::DepthW-1:0] DepthCap = jpp_pkg::DepthW'(MAX_DEPTH);

  logic                         in_string_q, in_string_d;
  logic                         escape_q, escape_d;
  logic [jpp_pkg::DepthW-1:0]   depth_q, depth_d;

  jpp_pkg::plan_t               plan_q, plan_d;
  logic [7:0]                   head_q, head_d;
  logic [7:0]                   tail_q, tail_d;
  logic [jpp_pkg::SpaceW-1:0]   space_q;
  logic                         last_q;

  logic                         out_valid_q;
  jpp_pkg::out_t                out_q;
  logic [7:0]                   emit_byte;

  // Decode of the incoming byte against the current parser state.
  always_comb begin
    in_string_d = in_string_q;
    escape_d    = escape_q;
    depth_d     = depth_q;
    plan_d      = '0;
    head_d      = in_data_i.text_byte;
    tail_d      = in_data_i.text_byte;
    if (in_data_i.text_byte == jpp_pkg::ChNul) begin
      escape_d = 1'b0;
    end else if (escape_q) begin
      escape_d        = 1'b0;
      plan_d.has_head = 1'b1;
    end else if (in_data_i.text_byte == jpp_pkg::ChBackslash) begin
      escape_d        = 1'b1;
      plan_d.has_head = 1'b1;
    end else if (in_data_i.text_byte == jpp_pkg::ChQuote) begin
      in_string_d     = !in_string_q;
      plan_d.has_head = 1'b1;
    end else if (in_string_q) begin
      plan_d.has_head = 1'b1;
    end else begin
      case (in_data_i.text_byte)
        jpp_pkg::ChLbrace: begin
          plan_d.has_head   = 1'b1;
          plan_d.has_indent = 1'b1;
          if (depth_q < DepthCap) begin
            depth_d = depth_q + 1'b1;
          end
        end
        jpp_pkg::ChRbrace: begin
          plan_d.has_indent = 1'b1;
          plan_d.has_tail   = 1'b1;
          if (depth_q != '0) begin
            depth_d = depth_q - 1'b1;
          end
        end
        jpp_pkg::ChComma: begin
          plan_d.has_head   = 1'b1;
          plan_d.has_indent = 1'b1;
        end
        jpp_pkg::ChColon: begin
          plan_d.has_head = 1'b1;
          plan_d.has_tail = 1'b1;
          tail_d          = jpp_pkg::ChSpace;
        end
        jpp_pkg::ChSpace, jpp_pkg::ChNewline: begin
          plan_d = '0;
        end
        default: begin
          plan_d.has_head = 1'b1;
        end
      endcase
    end
  end

  // Parser state; the end of a document returns it to the top level at
  // once, since the run plan already holds what the last byte needs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      escape_q    <= 1'b0;
      depth_q     <= '0;
    end else if (cmd_i.load) begin
      if (in_data_i.doc_last) begin
        in_string_q <= 1'b0;
        escape_q    <= 1'b0;
        depth_q     <= '0;
      end else begin
        in_string_q <= in_string_d;
        escape_q    <= escape_d;
        depth_q     <= depth_d;
      end
    end
  end

  // Run plan and indent counter; two spaces per level of the new depth.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      plan_q  <= plan_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      last_q  <= in_data_i.doc_last;
      space_q <= {depth_d, 1'b0};
    end else if (cmd_i.dec_space) begin
      space_q <= space_q - 1'b1;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      jpp_pkg::SelHead:    emit_byte = head_q;
      jpp_pkg::SelNewline: emit_byte = jpp_pkg::ChNewline;
      jpp_pkg::SelSpace:   emit_byte = jpp_pkg::ChSpace;
      jpp_pkg::SelTail:    emit_byte = tail_q;
      default:             emit_byte = head_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_byte <= emit_byte;
      out_q.run_last <= cmd_i.run_last;
      out_q.doc_end  <= cmd_i.run_last && last_q;
    end
  end

  assign status_o.in_plan    = plan_d;
  assign status_o.plan       = plan_q;
  assign status_o.space_zero = (space_q == '0);
  assign status_o.space_one  = (space_q == jpp_pkg::SpaceW'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/json_pretty_printer_top.sv
// Top level of the JSON pretty printer: joins the controller and datapath.
// Depends on jpp_pkg, jpp_ctrl and jpp_datapath.
`timescale 1ns / 1ps

// Streaming JSON re-indenter. Each request carries one text byte and a
// document-end flag, and produces a run of zero to 64 output bytes; run_last
// marks the final byte of each run and doc_end the final byte of a
// document's last request. A request is taken while the controller is idle;
// the controller then emits its bytes one at a time into the output register,
// holding while the output stalls. So a dropped byte (a NUL, or a space or
// newline outside a string) produces no output, most other bytes one, a
// colon two, and a brace or comma two plus two per indent level. A new
// request is taken as soon as the previous run has been issued, even while
// its last byte still waits in the output register. The parser state returns
// to the top level after a document's last byte. MAX_DEPTH (1 to 31) caps
// nesting.
module json_pretty_printer_top #(
  parameter int unsigned MAX_DEPTH = jpp_pkg::MaxDepthDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jpp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jpp_pkg::out_t out_data_o
);

  jpp_pkg::ctrl_cmd_t  cmd;
  jpp_pkg::dp_status_t status;

  jpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jpp_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
